// ===== rtl/rss_pkg.sv =====
// Shared constants, types and tables for the route segment stepper.
package rss_pkg;

    localparam int MAX_STEPS         = 63;
    localparam int CORDIC_ITERATIONS = 16;
    localparam int ATAN_LEN          = 24;

    // Datapath widths
    localparam int PW      = 24;                       // position / coordinate
    localparam int DW      = PW + 1;                   // coordinate difference
    localparam int SQW     = 2 * DW;                   // squared length
    localparam int VW      = 64;                       // root radicand
    localparam int RW      = 32;                       // root
    localparam int QW      = 12;                       // step quotient magnitude
    localparam int NUMW    = DW + 16;                  // dividend
    localparam int SW      = QW + 1;                   // signed step
    localparam int CW      = DW + 33;                  // CORDIC vector
    localparam int ZW      = 36;                       // CORDIC angle, Q.30
    localparam int HW      = 16;                       // heading
    localparam int AW      = PW + 2;                   // position accumulator
    localparam int STEP_W  = $clog2(MAX_STEPS + 2);    // step counter
    localparam int IDXW    = 5;                        // iteration index
    localparam int CNTW    = 6;                        // controller counter
    localparam int SQRT_ITERS = RW;

    localparam logic signed [ZW-1:0] PI_Q30 = 36'sd3373259426;
    localparam logic signed [HW-1:0] PI_Q12 = 16'sd12868;
    localparam logic signed [HW-1:0] TWO_PI_Q12 = 16'sd25736;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_COUNT,
        ST_SQRT,
        ST_DIVX,
        ST_DIVY,
        ST_CORDIC,
        ST_HEAD,
        ST_LOAD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic            capture;
        logic            square;
        logic            zero_setup;
        logic            count_step;
        logic            count_fix;
        logic            sqrt_init;
        logic            sqrt_step;
        logic            div_init_x;
        logic            div_init_y;
        logic            div_step;
        logic            div_store_x;
        logic            div_store_y;
        logic            cordic_init;
        logic            cordic_step;
        logic            head;
        logic            emit_first;
        logic            emit_next;
        logic [IDXW-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic zero_len;
        logic count_done;
        logic last;
    } status_t;

    // atan(2^-i) in Q.30
    function automatic logic signed [ZW-1:0] atan_q30(input logic [IDXW-1:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:    v = 36'sd843314857;
            5'd1:    v = 36'sd497837829;
            5'd2:    v = 36'sd263043837;
            5'd3:    v = 36'sd133525159;
            5'd4:    v = 36'sd67021687;
            5'd5:    v = 36'sd33543516;
            5'd6:    v = 36'sd16775851;
            5'd7:    v = 36'sd8388437;
            5'd8:    v = 36'sd4194283;
            5'd9:    v = 36'sd2097149;
            5'd10:   v = 36'sd1048576;
            5'd11:   v = 36'sd524288;
            5'd12:   v = 36'sd262144;
            5'd13:   v = 36'sd131072;
            5'd14:   v = 36'sd65536;
            5'd15:   v = 36'sd32768;
            5'd16:   v = 36'sd16384;
            5'd17:   v = 36'sd8192;
            5'd18:   v = 36'sd4096;
            5'd19:   v = 36'sd2048;
            5'd20:   v = 36'sd1024;
            5'd21:   v = 36'sd512;
            5'd22:   v = 36'sd256;
            5'd23:   v = 36'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/route_segment_stepper.sv =====
// Top level of the route segment stepper: controller plus datapath.
// Sequence: after the input transfer the segment is squared, then come the step count loop,
// the root, the x and y step divisions, the CORDIC and the heading before the first result
// can transfer; a zero-length segment goes straight to the first result.
// Results then leave one per cycle while m_ready is high; a new segment is taken
// once the last result of the previous one has transferred.
// Reset (synchronous, aresetn low) returns the controller to idle; no data is cleared.
module route_segment_stepper (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [rss_pkg::PW-1:0] s_start_x,
    input  logic signed [rss_pkg::PW-1:0] s_start_y,
    input  logic signed [rss_pkg::PW-1:0] s_end_x,
    input  logic signed [rss_pkg::PW-1:0] s_end_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [rss_pkg::PW-1:0] m_pos_x,
    output logic signed [rss_pkg::PW-1:0] m_pos_y,
    output logic signed [rss_pkg::HW-1:0] m_heading,
    output logic                          m_last_step,
    output logic                          m_cut_short
);
    import rss_pkg::*;

    cmd_t    cmd;
    status_t status;

    rss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rss_datapath u_dp (
        .aclk        (aclk),
        .cmd         (cmd),
        .status      (status),
        .s_start_x   (s_start_x),
        .s_start_y   (s_start_y),
        .s_end_x     (s_end_x),
        .s_end_y     (s_end_y),
        .m_pos_x     (m_pos_x),
        .m_pos_y     (m_pos_y),
        .m_heading   (m_heading),
        .m_last_step (m_last_step),
        .m_cut_short (m_cut_short)
    );

    // input and output sides never open together
    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while results pending");

    // accepted segment is not shown in the next cycle
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !m_valid)
        else $error("result appeared right after input transfer");

    // last transfer returns to idle
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_step) |=> (s_ready && !m_valid))
        else $error("block not idle after last result");

    // further results follow until the last one
    a_continue: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_step) |=> m_valid)
        else $error("result stream broke before last step");

endmodule

// ===== rtl/rss_ctrl.sv =====
// Sequencing controller for the route segment stepper.
module rss_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  rss_pkg::status_t status,
    output rss_pkg::cmd_t    cmd
);
    import rss_pkg::*;

    state_t          state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [CNTW-1:0] div_idx;

    assign div_idx = CNTW'(QW - 1) - cnt_reg;

    // hold state and iteration count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // sequence the phases of one segment
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_COUNT;
            end
            ST_COUNT: begin
                if (status.zero_len) begin
                    cmd.zero_setup = 1'b1;
                    state_next     = ST_LOAD;
                end else if (!status.count_done) begin
                    cmd.count_step = 1'b1;
                end else begin
                    cmd.count_fix = 1'b1;
                    cmd.sqrt_init = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (cnt_reg == CNTW'(SQRT_ITERS)) begin
                    cmd.div_init_x = 1'b1;
                    cnt_next       = '0;
                    state_next     = ST_DIVX;
                end else begin
                    cmd.sqrt_step = 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                end
            end
            ST_DIVX: begin
                if (cnt_reg == CNTW'(QW)) begin
                    cmd.div_store_x = 1'b1;
                    cmd.div_init_y  = 1'b1;
                    cnt_next        = '0;
                    state_next      = ST_DIVY;
                end else begin
                    cmd.div_step = 1'b1;
                    cmd.idx      = div_idx[IDXW-1:0];
                    cnt_next     = cnt_reg + 1'b1;
                end
            end
            ST_DIVY: begin
                if (cnt_reg == CNTW'(QW)) begin
                    cmd.div_store_y = 1'b1;
                    cmd.cordic_init = 1'b1;
                    cnt_next        = '0;
                    state_next      = ST_CORDIC;
                end else begin
                    cmd.div_step = 1'b1;
                    cmd.idx      = div_idx[IDXW-1:0];
                    cnt_next     = cnt_reg + 1'b1;
                end
            end
            ST_CORDIC: begin
                if (cnt_reg == CNTW'(CORDIC_ITERATIONS)) begin
                    state_next = ST_HEAD;
                end else begin
                    cmd.cordic_step = 1'b1;
                    cmd.idx         = cnt_reg[IDXW-1:0];
                    cnt_next        = cnt_reg + 1'b1;
                end
            end
            ST_HEAD: begin
                cmd.head   = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.emit_first = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (status.last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.emit_next = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/rss_datapath.sv =====
// Arithmetic datapath: length, root, step division, CORDIC heading, stepping.
module rss_datapath (
    input  logic                          aclk,
    input  rss_pkg::cmd_t                 cmd,
    output rss_pkg::status_t              status,
    input  logic signed [rss_pkg::PW-1:0] s_start_x,
    input  logic signed [rss_pkg::PW-1:0] s_start_y,
    input  logic signed [rss_pkg::PW-1:0] s_end_x,
    input  logic signed [rss_pkg::PW-1:0] s_end_y,
    output logic signed [rss_pkg::PW-1:0] m_pos_x,
    output logic signed [rss_pkg::PW-1:0] m_pos_y,
    output logic signed [rss_pkg::HW-1:0] m_heading,
    output logic                          m_last_step,
    output logic                          m_cut_short
);
    import rss_pkg::*;

    logic signed [PW-1:0]   sx_reg, sy_reg;
    logic signed [DW-1:0]   dx_reg, dy_reg;
    logic [SQW-1:0]         s_reg;
    logic [STEP_W-1:0]      n_reg, k_reg;
    logic                   cut_reg;
    logic [VW-1:0]          v_reg, res_reg, bit_reg;
    logic [NUMW-1:0]        rem_reg;
    logic [QW-1:0]          q_reg;
    logic                   dneg_reg;
    logic signed [SW-1:0]   stx_reg, sty_reg;
    logic signed [CW-1:0]   cx_reg, cy_reg;
    logic signed [ZW-1:0]   z_reg;
    logic signed [HW-1:0]   h_reg;
    logic signed [AW-1:0]   accx_reg, accy_reg;

    logic signed [SQW-1:0]  sq_x, sq_y;
    logic [2*STEP_W-1:0]    n_sq;
    logic [SQW-1:0]         n_sq_sh;
    logic [VW-1:0]          sq_sum;
    logic [RW-1:0]          root;
    logic signed [DW-1:0]   div_d;
    logic [DW-1:0]          div_mag;
    logic [NUMW-1:0]        numer;
    logic [RW+QW-1:0]       trial;
    logic signed [SW-1:0]   step_q;
    logic signed [DW-1:0]   ca, cb;
    logic signed [CW-1:0]   cx0, cy0, cx_sh, cy_sh;
    logic signed [ZW-1:0]   zt, zh;
    logic signed [AW-1:0]   stx_ext, sty_ext;

    // squared length terms and step-count test
    assign sq_x    = dx_reg * dx_reg;
    assign sq_y    = dy_reg * dy_reg;
    assign n_sq    = n_reg * n_reg;
    assign n_sq_sh = SQW'(n_sq) << 16;
    assign status.zero_len   = (s_reg == '0);
    assign status.count_done = (n_reg > STEP_W'(MAX_STEPS)) || (n_sq_sh >= s_reg);
    assign status.last       = (k_reg == n_reg + 1'b1);

    // root and divider operands
    assign sq_sum  = res_reg + bit_reg;
    assign root    = res_reg[RW-1:0];
    assign div_d   = cmd.div_init_y ? dy_reg : dx_reg;
    assign div_mag = div_d[DW-1] ? DW'(-div_d) : DW'(div_d);
    assign numer   = NUMW'({div_mag, 15'b0}) + NUMW'(root >> 1);
    assign trial   = (RW+QW)'(root) << cmd.idx;
    assign step_q  = dneg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

    // CORDIC operands: mirror the vector when start x is not positive
    assign ca    = (sx_reg > 0) ? dx_reg : -dx_reg;
    assign cb    = (sx_reg > 0) ? dy_reg : -dy_reg;
    assign cx0   = {{(CW-DW){ca[DW-1]}}, ca} <<< 30;
    assign cy0   = {{(CW-DW){cb[DW-1]}}, cb} <<< 30;
    assign cx_sh = cx_reg >>> cmd.idx;
    assign cy_sh = cy_reg >>> cmd.idx;

    // round heading to Q4.12
    assign zt = z_reg - ((sx_reg < 0) ? PI_Q30 : ZW'(0)) + ZW'(1 << 17);
    assign zh = zt >>> 18;

    assign stx_ext = AW'(stx_reg);
    assign sty_ext = AW'(sty_reg);

    always_ff @(posedge aclk) begin
        // capture segment
        if (cmd.capture) begin
            sx_reg  <= s_start_x;
            sy_reg  <= s_start_y;
            dx_reg  <= DW'(s_end_x) - DW'(s_start_x);
            dy_reg  <= DW'(s_end_y) - DW'(s_start_y);
            n_reg   <= '0;
            cut_reg <= 1'b0;
        end
        if (cmd.square) begin
            s_reg <= SQW'($unsigned(sq_x)) + SQW'($unsigned(sq_y));
        end
        // count steps, clamp long segments
        if (cmd.count_step) begin
            n_reg <= n_reg + 1'b1;
        end
        if (cmd.count_fix && (n_reg > STEP_W'(MAX_STEPS))) begin
            n_reg   <= STEP_W'(MAX_STEPS);
            cut_reg <= 1'b1;
        end
        if (cmd.zero_setup) begin
            n_reg   <= '0;
            cut_reg <= 1'b1;
            stx_reg <= '0;
            sty_reg <= '0;
            h_reg   <= '0;
        end
        // integer square root, one result bit per cycle
        if (cmd.sqrt_init) begin
            v_reg   <= {s_reg, 14'b0};
            res_reg <= '0;
            bit_reg <= VW'(1) << 62;
        end
        if (cmd.sqrt_step) begin
            if (v_reg >= sq_sum) begin
                v_reg   <= v_reg - sq_sum;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        // restoring division for the unit step
        if (cmd.div_init_x || cmd.div_init_y) begin
            rem_reg  <= numer;
            q_reg    <= '0;
            dneg_reg <= div_d[DW-1];
        end
        if (cmd.div_step && ((RW+QW)'(rem_reg) >= trial)) begin
            rem_reg        <= NUMW'((RW+QW)'(rem_reg) - trial);
            q_reg[cmd.idx[$clog2(QW)-1:0]] <= 1'b1;
        end
        if (cmd.div_store_x) begin
            stx_reg <= step_q;
        end
        if (cmd.div_store_y) begin
            sty_reg <= step_q;
        end
        // vectoring CORDIC
        if (cmd.cordic_init) begin
            if (cx0 < 0) begin
                z_reg  <= (cy0 >= 0) ? PI_Q30 : -PI_Q30;
                cx_reg <= -cx0;
                cy_reg <= -cy0;
            end else begin
                z_reg  <= '0;
                cx_reg <= cx0;
                cy_reg <= cy0;
            end
        end
        if (cmd.cordic_step) begin
            if (cy_reg >= 0) begin
                cx_reg <= cx_reg + cy_sh;
                cy_reg <= cy_reg - cx_sh;
                z_reg  <= z_reg + atan_q30(cmd.idx);
            end else begin
                cx_reg <= cx_reg - cy_sh;
                cy_reg <= cy_reg + cx_sh;
                z_reg  <= z_reg - atan_q30(cmd.idx);
            end
        end
        // saturate heading; zero when start x is zero
        if (cmd.head) begin
            if (sx_reg == 0) begin
                h_reg <= '0;
            end else if (zh > ZW'(PI_Q12)) begin
                h_reg <= PI_Q12;
            end else if (zh < -ZW'(TWO_PI_Q12)) begin
                h_reg <= -TWO_PI_Q12;
            end else begin
                h_reg <= zh[HW-1:0];
            end
        end
        // advance positions
        if (cmd.emit_first) begin
            accx_reg <= AW'(sx_reg) + stx_ext;
            accy_reg <= AW'(sy_reg) + sty_ext;
            k_reg    <= STEP_W'(1);
        end
        if (cmd.emit_next) begin
            accx_reg <= accx_reg + stx_ext;
            accy_reg <= accy_reg + sty_ext;
            k_reg    <= k_reg + 1'b1;
        end
    end

    // saturate positions to the coordinate range
    localparam logic signed [AW-1:0] POS_MAX = AW'((1 << (PW - 1)) - 1);
    localparam logic signed [AW-1:0] POS_MIN = -AW'(1 << (PW - 1));

    always_comb begin
        if (accx_reg > POS_MAX) begin
            m_pos_x = POS_MAX[PW-1:0];
        end else if (accx_reg < POS_MIN) begin
            m_pos_x = POS_MIN[PW-1:0];
        end else begin
            m_pos_x = accx_reg[PW-1:0];
        end
        if (accy_reg > POS_MAX) begin
            m_pos_y = POS_MAX[PW-1:0];
        end else if (accy_reg < POS_MIN) begin
            m_pos_y = POS_MIN[PW-1:0];
        end else begin
            m_pos_y = accy_reg[PW-1:0];
        end
    end

    assign m_heading   = h_reg;
    assign m_last_step = status.last;
    assign m_cut_short = cut_reg;

endmodule
